FILE: hdl/mrcms_pkg.sv
`default_nettype none

package mrcms_pkg;

    localparam int MAX_ROWS   = 64;
    localparam int MAX_COLS   = 64;
    localparam int DATA_WIDTH = 16;
    localparam int SUM_W      = 22;
    localparam int IDX_W      = 6;
    localparam int CNT_W      = 7;
    localparam int ADDR_W     = 3;
    localparam int CFG_W      = 32;

    // result queue
    localparam int FIFO_DEPTH = 3;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 2;

    // register index, taken from paddr[2]
    localparam logic REG_ROW_COUNT = 1'b0;
    localparam logic REG_COL_COUNT = 1'b1;

    // one result, best_row_sum in the low bits
    typedef struct packed {
        logic        [IDX_W-1:0] best_col;
        logic signed [SUM_W-1:0] best_col_sum;
        logic        [IDX_W-1:0] best_row;
        logic signed [SUM_W-1:0] best_row_sum;
    } t_result;

    // last usable index for a count register; zero acts as one, large values saturate
    function automatic logic [IDX_W-1:0] last_index(input logic [CNT_W-1:0] cnt,
                                                      input logic [CNT_W-1:0] max_cnt);
        logic [CNT_W-1:0] lim;
        lim = cnt;
        if (cnt == '0) begin
            lim = CNT_W'(1);
        end else if (cnt > max_cnt) begin
            lim = max_cnt;
        end
        last_index = IDX_W'(lim - CNT_W'(1));
    endfunction

endpackage

`default_nettype wire

FILE: hdl/mrcms_out_fifo.sv
`default_nettype none

module mrcms_out_fifo (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_push,
    input  wire  mrcms_pkg::t_result             i_data,
    input  wire                                  i_pop,
    output logic                                 o_valid,
    output mrcms_pkg::t_result                   o_data,
    output logic [mrcms_pkg::FIFO_CNT_W-1:0]     o_count
);

    mrcms_pkg::t_result r_mem [mrcms_pkg::FIFO_DEPTH];
    logic [mrcms_pkg::FIFO_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [mrcms_pkg::FIFO_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [mrcms_pkg::FIFO_CNT_W-1:0] r_count,  n_count;
    logic                             w_pop;

    assign w_pop = i_pop && (r_count != '0);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == mrcms_pkg::FIFO_PTR_W'(mrcms_pkg::FIFO_DEPTH - 1)) ?
                       '0 : r_wr_ptr + mrcms_pkg::FIFO_PTR_W'(1);
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == mrcms_pkg::FIFO_PTR_W'(mrcms_pkg::FIFO_DEPTH - 1)) ?
                       '0 : r_rd_ptr + mrcms_pkg::FIFO_PTR_W'(1);
        end
        if (i_push && !w_pop) begin
            n_count = r_count + mrcms_pkg::FIFO_CNT_W'(1);
        end else if (!i_push && w_pop) begin
            n_count = r_count - mrcms_pkg::FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

`default_nettype wire

FILE: hdl/matrix_row_column_max_sum.sv
// A matrix result is valid once it is pushed from stage 1 into the result queue.
// Throughput: one element per cycle while ready is high; the column accumulator RAM is
//   read on accept, written back the cycle after, with a bypass for back-to-back hits.
// Input ready drops only while the three-entry result queue could overflow.
// Reset (synchronous, active low): row_count = 6, col_count = 7, positions and sums zero.
// No clearing pass: row-0 elements overwrite the column accumulators.
`default_nettype none

module matrix_row_column_max_sum (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // element stream
    input  wire                                  i_s_tvalid,
    output logic                                 o_s_tready,
    input  wire  [15:0]                          i_s_tdata,   // [15:0] element
    // result stream
    output logic                                 o_m_tvalid,
    input  wire                                  i_m_tready,
    output logic [55:0]                          o_m_tdata,   // [21:0] best_row_sum,
                                                              // [27:22] best_row,
                                                              // [49:28] best_col_sum,
                                                              // [55:50] best_col
    // register port
    input  wire                                  i_psel,
    input  wire                                  i_penable,
    input  wire                                  i_pwrite,
    input  wire  [mrcms_pkg::ADDR_W-1:0]         i_paddr,
    input  wire  [mrcms_pkg::CFG_W-1:0]          i_pwdata,
    output logic [mrcms_pkg::CFG_W-1:0]          o_prdata,
    output logic                                 o_pready
);

    localparam int SW = mrcms_pkg::SUM_W;
    localparam int IW = mrcms_pkg::IDX_W;
    localparam int CW = mrcms_pkg::CNT_W;
    localparam int DW = mrcms_pkg::DATA_WIDTH;

    // ---------------- register port ----------------
    logic [CW-1:0] r_row_count;
    logic [CW-1:0] r_col_count;
    logic          w_cfg_wr;

    assign o_pready = 1'b1;
    assign w_cfg_wr = i_psel && i_penable && i_pwrite && o_pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= CW'(6);
            r_col_count <= CW'(7);
        end else if (w_cfg_wr) begin
            case (i_paddr[2])
                mrcms_pkg::REG_ROW_COUNT: r_row_count <= i_pwdata[CW-1:0];
                mrcms_pkg::REG_COL_COUNT: r_col_count <= i_pwdata[CW-1:0];
                default:                  r_row_count <= r_row_count;
            endcase
        end
    end

    always_comb begin
        case (i_paddr[2])
            mrcms_pkg::REG_ROW_COUNT: o_prdata = {{(mrcms_pkg::CFG_W-CW){1'b0}}, r_row_count};
            mrcms_pkg::REG_COL_COUNT: o_prdata = {{(mrcms_pkg::CFG_W-CW){1'b0}}, r_col_count};
            default:                  o_prdata = '0;
        endcase
    end

    // clamped last indices
    logic [IW-1:0] w_rows_last;
    logic [IW-1:0] w_cols_last;

    assign w_rows_last = mrcms_pkg::last_index(r_row_count, CW'(mrcms_pkg::MAX_ROWS));
    assign w_cols_last = mrcms_pkg::last_index(r_col_count, CW'(mrcms_pkg::MAX_COLS));

    // ---------------- stage 0: accept, address, RAM read ----------------
    logic          w_accept;
    logic [IW-1:0] r_row_pos;
    logic [IW-1:0] r_col_pos;

    // stage 1 pipeline register
    logic                 r_s1_valid;
    logic [IW-1:0]        r_s1_col;
    logic [IW-1:0]        r_s1_row;
    logic signed [DW-1:0] r_s1_elem;
    logic                 r_s1_row0;
    logic                 r_s1_last_row;
    logic                 r_s1_row_end;

    // column accumulators
    logic signed [SW-1:0] r_col_mem [mrcms_pkg::MAX_COLS];
    logic signed [SW-1:0] r_rd_data;

    // write-back bypass: the read in the same cycle as a write misses it
    logic                 r_byp_valid;
    logic [IW-1:0]        r_byp_addr;
    logic signed [SW-1:0] r_byp_data;

    logic signed [SW-1:0] r_row_sum;
    logic signed [SW-1:0] r_best_row_sum;
    logic [IW-1:0]        r_best_row;
    logic signed [SW-1:0] r_best_col_sum;
    logic [IW-1:0]        r_best_col;

    logic [mrcms_pkg::FIFO_CNT_W-1:0] w_fifo_count;
    logic                             w_final_pending;
    logic                             w_push;
    mrcms_pkg::t_result               w_push_data;
    mrcms_pkg::t_result               w_pop_data;

    // a matrix-closing element in stage 1 still needs a queue slot
    assign w_final_pending = r_s1_valid && r_s1_row_end && r_s1_last_row;
    assign o_s_tready = ({1'b0, w_fifo_count} + {2'b00, w_final_pending}) <= 3'd2;
    assign w_accept   = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_pos  <= '0;
            r_col_pos  <= '0;
            r_s1_valid <= 1'b0;
        end else if (w_cfg_wr) begin
            // a register write drops the matrix in progress
            r_row_pos  <= '0;
            r_col_pos  <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
            if (w_accept) begin
                if (r_col_pos == w_cols_last) begin
                    r_col_pos <= '0;
                    r_row_pos <= (r_row_pos == w_rows_last) ? '0 : r_row_pos + IW'(1);
                end else begin
                    r_col_pos <= r_col_pos + IW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_col      <= r_col_pos;
            r_s1_row      <= r_row_pos;
            r_s1_elem     <= i_s_tdata[DW-1:0];
            r_s1_row0     <= (r_row_pos == '0);
            r_s1_last_row <= (r_row_pos == w_rows_last);
            r_s1_row_end  <= (r_col_pos == w_cols_last);
            r_rd_data     <= r_col_mem[r_col_pos];
        end
    end

    // ---------------- stage 1: accumulate, compare, write back ----------------
    logic signed [SW-1:0] w_elem;
    logic signed [SW-1:0] w_old_col;
    logic signed [SW-1:0] w_col_sum;
    logic signed [SW-1:0] w_row_sum;
    logic                 w_take_col;
    logic                 w_take_row;
    logic signed [SW-1:0] n_best_row_sum;
    logic [IW-1:0]        n_best_row;
    logic signed [SW-1:0] n_best_col_sum;
    logic [IW-1:0]        n_best_col;

    assign w_elem = {{(SW-DW){r_s1_elem[DW-1]}}, r_s1_elem};

    always_comb begin
        // row 0 starts every column from zero
        if (r_s1_row0) begin
            w_old_col = '0;
        end else if (r_byp_valid && (r_byp_addr == r_s1_col)) begin
            w_old_col = r_byp_data;
        end else begin
            w_old_col = r_rd_data;
        end
    end

    assign w_col_sum = w_old_col + w_elem;
    assign w_row_sum = r_row_sum + w_elem;

    // first one always taken, then only strictly greater
    assign w_take_col = r_s1_valid && r_s1_last_row &&
                        ((r_s1_col == '0) || (w_col_sum > r_best_col_sum));
    assign w_take_row = r_s1_valid && r_s1_row_end &&
                        (r_s1_row0 || (w_row_sum > r_best_row_sum));

    assign n_best_col_sum = w_take_col ? w_col_sum : r_best_col_sum;
    assign n_best_col     = w_take_col ? r_s1_col  : r_best_col;
    assign n_best_row_sum = w_take_row ? w_row_sum : r_best_row_sum;
    assign n_best_row     = w_take_row ? r_s1_row  : r_best_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_sum      <= '0;
            r_best_row_sum <= '0;
            r_best_row     <= '0;
            r_best_col_sum <= '0;
            r_best_col     <= '0;
            r_byp_valid    <= 1'b0;
        end else if (w_cfg_wr) begin
            r_row_sum      <= '0;
            r_best_row_sum <= '0;
            r_best_row     <= '0;
            r_best_col_sum <= '0;
            r_best_col     <= '0;
            r_byp_valid    <= 1'b0;
        end else begin
            r_byp_valid <= r_s1_valid;
            if (r_s1_valid) begin
                r_row_sum      <= r_s1_row_end ? '0 : w_row_sum;
                r_best_row_sum <= n_best_row_sum;
                r_best_row     <= n_best_row;
                r_best_col_sum <= n_best_col_sum;
                r_best_col     <= n_best_col;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_col_mem[r_s1_col] <= w_col_sum;
            r_byp_addr          <= r_s1_col;
            r_byp_data          <= w_col_sum;
        end
    end

    // ---------------- result queue ----------------
    assign w_push = w_final_pending;

    always_comb begin
        w_push_data.best_row_sum = n_best_row_sum;
        w_push_data.best_row     = n_best_row;
        w_push_data.best_col_sum = n_best_col_sum;
        w_push_data.best_col     = n_best_col;
    end

    mrcms_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .i_pop   (i_m_tready),
        .o_valid (o_m_tvalid),
        .o_data  (w_pop_data),
        .o_count (w_fifo_count)
    );

    assign o_m_tdata = w_pop_data;

endmodule

`default_nettype wire

FILE: hdl/mrcms_checker.sv
`default_nettype none

module mrcms_checker (
    input wire                                  i_clk,
    input wire                                  i_rst_n,
    input wire                                  i_s_tvalid,
    input wire                                  o_s_tready,
    input wire                                  o_m_tvalid,
    input wire                                  i_m_tready,
    input wire [55:0]                           o_m_tdata,
    input wire                                  o_pready
);

    logic w_s_acc;
    assign w_s_acc = i_s_tvalid && o_s_tready;

    // a stalled result request keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("result changed while stalled");

    // the result queue starts empty after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    // a result into an empty queue traces back to an accepted element request
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_rst_n == 1'b0 && $past(i_rst_n, 2) && $rose(o_m_tvalid)) |-> $past(w_s_acc, 2))
        else $error("result without a matching element request");

    // register port never waits
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pready)
        else $error("pready low");

endmodule

bind matrix_row_column_max_sum mrcms_checker u_mrcms_checker (.*);

`default_nettype wire

FILE: sim/testbench.sv
module testbench;

    // Watchdog limit: cycles in a row with no request, no result and no register access.
    localparam int QUIET_LIMIT = 2000;
    // Each random phase stops once it has sent about this many elements.
    localparam int PHASE_ITEMS = 250;

    // Idle percentages for each random phase: none, sender only, receiver only, both.
    localparam int SRC_IDLE[4]   = '{0, 84, 0, 34};
    localparam int SINK_STALL[4] = '{0, 0, 84, 34};

    // Out-of-range and full-size shapes, mixed in among the small random ones.
    localparam logic [6:0] WIDE_ROWS[5] = '{7'd1, 7'd127, 7'd0, 7'd65, 7'd64};
    localparam logic [6:0] WIDE_COLS[5] = '{7'd127, 7'd1, 7'd64, 7'd2, 7'd1};

    typedef enum logic [1:0] {
        OP_ROWS,
        OP_COLS,
        OP_ELEM
    } t_step_kind;

    // One row of the directed table. For OP_ELEM rows with typed set, the
    // result fields hold the result that this element must complete.
    typedef struct packed {
        t_step_kind                         kind;
        logic [31:0]                        value;
        logic                               typed;
        logic signed [mrcms_pkg::SUM_W-1:0] row_sum;
        logic [mrcms_pkg::IDX_W-1:0]        row;
        logic signed [mrcms_pkg::SUM_W-1:0] col_sum;
        logic [mrcms_pkg::IDX_W-1:0]        col;
    } t_dir_step;

    localparam int DIR_LEN = 29;
    localparam t_dir_step DIR_STEPS[DIR_LEN] = '{
        // 1x1: both extremes of the element, then zero
        '{OP_ROWS, 32'd1, 1'b0, 0, 0, 0, 0},
        '{OP_COLS, 32'd1, 1'b0, 0, 0, 0, 0},
        '{OP_ELEM, 32'h7FFF, 1'b1, 32767, 0, 32767, 0},
        '{OP_ELEM, 32'h8000, 1'b1, -32768, 0, -32768, 0},
        '{OP_ELEM, 32'h0, 1'b1, 0, 0, 0, 0},
        // zero counts act as one; upper data bits are dropped by the register
        '{OP_ROWS, 32'hFFFF_FF80, 1'b0, 0, 0, 0, 0},
        '{OP_COLS, 32'h0000_0080, 1'b0, 0, 0, 0, 0},
        '{OP_ELEM, 32'd5, 1'b1, 5, 0, 5, 0},
        // 2x2: all ties keep index zero
        '{OP_ROWS, 32'd2, 1'b0, 0, 0, 0, 0},
        '{OP_COLS, 32'd2, 1'b0, 0, 0, 0, 0},
        '{OP_ELEM, 32'd1, 1'b0, 0, 0, 0, 0},
        '{OP_ELEM, 32'd1, 1'b0, 0, 0, 0, 0},
        '{OP_ELEM, 32'd1, 1'b0, 0, 0, 0, 0},
        '{OP_ELEM, 32'd1, 1'b1, 2, 0, 2, 0},
        // second row wins, column sums tie
        '{OP_ELEM, -5, 1'b0, 0, 0, 0, 0},
        '{OP_ELEM, -5, 1'b0, 0, 0, 0, 0},
        '{OP_ELEM, 32'd3, 1'b0, 0, 0, 0, 0},
        '{OP_ELEM, 32'd3, 1'b1, 6, 1, -2, 0},
        // first row wins, second column wins
        '{OP_ELEM, 32'd1, 1'b0, 0, 0, 0, 0},
        '{OP_ELEM, 32'd9, 1'b0, 0, 0, 0, 0},
        '{OP_ELEM, 32'd0, 1'b0, 0, 0, 0, 0},
        '{OP_ELEM, 32'd0, 1'b1, 10, 0, 9, 1},
        // half a matrix, then a register write throws it away
        '{OP_ELEM, 32'd7, 1'b0, 0, 0, 0, 0},
        '{OP_ELEM, 32'd8, 1'b0, 0, 0, 0, 0},
        '{OP_COLS, 32'd2, 1'b0, 0, 0, 0, 0},
        '{OP_ELEM, -1, 1'b0, 0, 0, 0, 0},
        '{OP_ELEM, -2, 1'b0, 0, 0, 0, 0},
        '{OP_ELEM, -3, 1'b0, 0, 0, 0, 0},
        '{OP_ELEM, -4, 1'b1, -3, 0, -4, 0}
    };

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_s_tvalid  = 1'b0;
    logic [15:0]                   i_s_tdata   = '0;
    logic                          i_m_tready  = 1'b0;
    logic                          i_psel      = 1'b0;
    logic                          i_penable   = 1'b0;
    logic                          i_pwrite    = 1'b0;
    logic [mrcms_pkg::ADDR_W-1:0]  i_paddr     = '0;
    logic [mrcms_pkg::CFG_W-1:0]   i_pwdata    = '0;
    wire                           o_s_tready;
    wire                           o_m_tvalid;
    wire  [55:0]                   o_m_tdata;
    wire  [mrcms_pkg::CFG_W-1:0]   o_prdata;
    wire                           o_pready;

    matrix_row_column_max_sum uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_psel     (i_psel),
        .i_penable  (i_penable),
        .i_pwrite   (i_pwrite),
        .i_paddr    (i_paddr),
        .i_pwdata   (i_pwdata),
        .o_prdata   (o_prdata),
        .o_pready   (o_pready)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor: register mirrors plus a private copy of the matrix state
    // ------------------------------------------------------------------
    logic [mrcms_pkg::CNT_W-1:0]        cfg_rows = 7'd6;
    logic [mrcms_pkg::CNT_W-1:0]        cfg_cols = 7'd7;
    int                                 row_at;
    int                                 col_at;
    logic signed [mrcms_pkg::SUM_W-1:0] row_run;
    logic signed [mrcms_pkg::SUM_W-1:0] col_tally[mrcms_pkg::MAX_COLS];
    logic signed [mrcms_pkg::SUM_W-1:0] lead_row_sum;
    int                                 lead_row;
    logic signed [mrcms_pkg::SUM_W-1:0] lead_col_sum;
    int                                 lead_col;

    // Results still owed by the block, oldest first.
    mrcms_pkg::t_result pending_maxima[$];

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int bad_count      = 0;
    int quiet_cycles   = 0;

    function automatic void reset_tally();
        row_at       = 0;
        col_at       = 0;
        row_run      = '0;
        lead_row_sum = '0;
        lead_row     = 0;
        lead_col_sum = '0;
        lead_col     = 0;
        foreach (col_tally[k]) col_tally[k] = '0;
    endfunction

    // Count register as the block uses it: zero means one, above the max saturates.
    function automatic int fit_count(input logic [mrcms_pkg::CNT_W-1:0] cnt, input int top);
        if (cnt == '0) return 1;
        if (int'(cnt) > top) return top;
        return int'(cnt);
    endfunction

    // Folds one element into the sums. Returns 1 with the matrix result when
    // the element closes the last row.
    function automatic bit take_element(input logic [15:0] raw,
                                        output mrcms_pkg::t_result res);
        int                                 rows;
        int                                 cols;
        int                                 c;
        logic signed [mrcms_pkg::SUM_W-1:0] e;
        rows = fit_count(cfg_rows, mrcms_pkg::MAX_ROWS);
        cols = fit_count(cfg_cols, mrcms_pkg::MAX_COLS);
        c    = col_at;
        e    = {{(mrcms_pkg::SUM_W-16){raw[15]}}, raw};
        res  = '0;
        row_run      = row_run + e;
        col_tally[c] = col_tally[c] + e;
        // column totals are only final while the last row goes by
        if (row_at == rows - 1 && (c == 0 || col_tally[c] > lead_col_sum)) begin
            lead_col_sum = col_tally[c];
            lead_col     = c;
        end
        if (c != cols - 1) begin
            col_at = c + 1;
            return 1'b0;
        end
        if (row_at == 0 || row_run > lead_row_sum) begin
            lead_row_sum = row_run;
            lead_row     = row_at;
        end
        row_run = '0;
        col_at  = 0;
        if (row_at != rows - 1) begin
            row_at++;
            return 1'b0;
        end
        res.best_row_sum = lead_row_sum;
        res.best_row     = mrcms_pkg::IDX_W'(lead_row);
        res.best_col_sum = lead_col_sum;
        res.best_col     = mrcms_pkg::IDX_W'(lead_col);
        reset_tally();
        return 1'b1;
    endfunction

    task automatic flag(input string msg);
        bad_count++;
        if (bad_count <= 10) $display("ERROR: %s", msg);
    endtask

    // ------------------------------------------------------------------
    // Element side
    // ------------------------------------------------------------------
    // Sends one element, with random idle cycles ahead of it. When the
    // request is taken the predictor runs; a typed result, if given,
    // replaces the predicted one in the queue.
    task automatic push_element(input logic [15:0] d, input bit typed,
                                input mrcms_pkg::t_result want);
        mrcms_pkg::t_result got;
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= d;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        if (take_element(d, got)) pending_maxima.push_back(typed ? want : got);
    endtask

    // Drains the block: nothing owed, then a margin for elements that
    // close no matrix but may still sit in the accumulator pipeline.
    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (pending_maxima.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Mixes full-range values with small ones (ties), the extremes and zero.
    function automatic logic [15:0] pick_element();
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: return 16'($urandom());
            6, 7:             return 16'($signed($urandom_range(4)) - 2);
            8:                return $urandom_range(1) ? 16'h7FFF : 16'h8000;
            default:          return 16'h0000;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------
    // One transfer (setup, access), then a return to idle so that the next
    // transfer never drives psel twice in one step.
    task automatic apb_access(input bit wr, input logic sel, input logic [31:0] data,
                              output logic [31:0] rdata);
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= wr;
        i_paddr   <= {sel, 2'b00};
        i_pwdata  <= data;
        @(posedge i_clk);
        i_penable <= 1'b1;
        @(posedge i_clk);
        while (!o_pready) @(posedge i_clk);
        rdata = o_prdata;
        if (wr) begin
            if (sel == mrcms_pkg::REG_ROW_COUNT) cfg_rows = data[mrcms_pkg::CNT_W-1:0];
            else                                 cfg_cols = data[mrcms_pkg::CNT_W-1:0];
            // any write drops the matrix in progress
            reset_tally();
        end
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_register(input logic sel);
        logic [31:0] rd;
        logic [31:0] want;
        want = {25'd0, (sel == mrcms_pkg::REG_ROW_COUNT) ? cfg_rows : cfg_cols};
        apb_access(1'b0, sel, '0, rd);
        if (rd !== want)
            flag($sformatf("register %0d read: expected %0d, got %0d", sel, want, rd));
    endtask

    task automatic set_register(input logic sel, input logic [31:0] data);
        logic [31:0] rd;
        apb_access(1'b1, sel, data, rd);
        check_register(sel);
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls and the field-by-field check
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        mrcms_pkg::t_result got;
        mrcms_pkg::t_result want;
        i_m_tready <= ($urandom_range(99) >= sink_stall_pct);
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = mrcms_pkg::t_result'(o_m_tdata);
            if (pending_maxima.size() == 0) begin
                flag($sformatf("result with nothing pending: %h", o_m_tdata));
            end else begin
                want = pending_maxima.pop_front();
                if (got.best_row_sum !== want.best_row_sum)
                    flag($sformatf("best_row_sum: expected %0d, got %0d",
                                   want.best_row_sum, got.best_row_sum));
                if (got.best_row !== want.best_row)
                    flag($sformatf("best_row: expected %0d, got %0d",
                                   want.best_row, got.best_row));
                if (got.best_col_sum !== want.best_col_sum)
                    flag($sformatf("best_col_sum: expected %0d, got %0d",
                                   want.best_col_sum, got.best_col_sum));
                if (got.best_col !== want.best_col)
                    flag($sformatf("best_col: expected %0d, got %0d",
                                   want.best_col, got.best_col));
            end
        end
    end

    // Watchdog: any request, result or register transfer counts as progress.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
                    || (i_psel && i_penable && o_pready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("simulation failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        mrcms_pkg::t_result want;
        mrcms_pkg::t_result none;
        int                 sent;
        int                 grp;
        int                 n_mat;
        int                 span_rows;
        int                 span_cols;
        int                 count;
        logic [6:0]         r;
        logic [6:0]         c;
        logic [31:0]        w;

        none = '0;
        reset_tally();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // register values out of reset
        check_register(mrcms_pkg::REG_ROW_COUNT);
        check_register(mrcms_pkg::REG_COL_COUNT);

        // directed table, no idling
        foreach (DIR_STEPS[k]) begin
            case (DIR_STEPS[k].kind)
                OP_ROWS: begin
                    settle();
                    set_register(mrcms_pkg::REG_ROW_COUNT, DIR_STEPS[k].value);
                end
                OP_COLS: begin
                    settle();
                    set_register(mrcms_pkg::REG_COL_COUNT, DIR_STEPS[k].value);
                end
                default: begin
                    want.best_row_sum = DIR_STEPS[k].row_sum;
                    want.best_row     = DIR_STEPS[k].row;
                    want.best_col_sum = DIR_STEPS[k].col_sum;
                    want.best_col     = DIR_STEPS[k].col;
                    push_element(DIR_STEPS[k].value[15:0], DIR_STEPS[k].typed, want);
                end
            endcase
        end

        // random part: groups of matrices under one shape, sometimes with
        // a trailing partial matrix that the next register write abandons
        grp = 0;
        for (int ph = 0; ph < 4; ph++) begin
            src_idle_pct   = SRC_IDLE[ph];
            sink_stall_pct = SINK_STALL[ph];
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if (grp % 5 == 0) begin
                    r     = WIDE_ROWS[(grp / 5) % 5];
                    c     = WIDE_COLS[(grp / 5) % 5];
                    n_mat = 1;
                end else begin
                    r     = 7'($urandom_range(6, 1));
                    c     = 7'($urandom_range(6, 1));
                    n_mat = $urandom_range(3, 1);
                end
                grp++;
                settle();
                w = $urandom();
                w[6:0] = r;
                set_register(mrcms_pkg::REG_ROW_COUNT, w);
                w = $urandom();
                w[6:0] = c;
                set_register(mrcms_pkg::REG_COL_COUNT, w);
                span_rows = fit_count(r, mrcms_pkg::MAX_ROWS);
                span_cols = fit_count(c, mrcms_pkg::MAX_COLS);
                count = n_mat * span_rows * span_cols;
                if (span_rows * span_cols > 1 && $urandom_range(3) == 0)
                    count += $urandom_range(span_rows * span_cols - 1, 1);
                for (int k = 0; k < count; k++) push_element(pick_element(), 1'b0, none);
                sent += count;
            end
        end

        // wind down: everything owed, then a margin for stray results
        i_s_tvalid <= 1'b0;
        while (pending_maxima.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (bad_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
